>>> design/dss_pkg.sv
`default_nettype none
package dss_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN_GO,
        ST_SIN_WAIT,
        ST_TERM_A,
        ST_TERM_B,
        ST_TERM_C,
        ST_TERM_D,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C
    } dss_state_t;

    typedef enum logic [1:0] {
        SN_IDLE,
        SN_LOAD,
        SN_DIV,
        SN_DONE
    } sin_state_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] value;
    } sin_stat_t;

    // configuration register indexes
    localparam logic [7:0] REG_SAMPLES_PER_STEP = 8'd0;
    localparam logic [7:0] REG_KICK_PATTERN     = 8'd1;
    localparam logic [7:0] REG_SNARE_PATTERN    = 8'd2;
    localparam logic [7:0] REG_HAT_PATTERN      = 8'd3;
    localparam logic [7:0] REG_STAB_PATTERN     = 8'd4;

    localparam logic [15:0] RST_SAMPLES_PER_STEP = 16'd5168;
    localparam logic [15:0] RST_KICK_PATTERN     = 16'd4369;
    localparam logic [15:0] RST_SNARE_PATTERN    = 16'd17476;
    localparam logic [15:0] RST_HAT_PATTERN      = 16'd65535;
    localparam logic [15:0] RST_STAB_PATTERN     = 16'd4112;

    // sine slots
    localparam logic [1:0] SIN_KICK = 2'd0;
    localparam logic [1:0] SIN_SUB  = 2'd1;
    localparam logic [1:0] SIN_STAB = 2'd2;

    // mix terms
    localparam logic [2:0] TERM_KICK  = 3'd0;
    localparam logic [2:0] TERM_SNARE = 3'd1;
    localparam logic [2:0] TERM_HAT   = 3'd2;
    localparam logic [2:0] TERM_SUB   = 3'd3;
    localparam logic [2:0] TERM_STAB  = 3'd4;

    localparam logic [15:0] ENV_ONE  = 16'd32768;
    localparam logic [15:0] ENV_HALF = 16'd16384;

    localparam logic [15:0] GAIN_KICK  = 16'd26214;
    localparam logic [15:0] GAIN_SNARE = 16'd16384;
    localparam logic [15:0] GAIN_HAT   = 16'd9830;
    localparam logic [15:0] GAIN_SUB   = 16'd9830;
    localparam logic [15:0] GAIN_STAB  = 16'd6554;

    localparam logic [15:0] DECAY_KICK  = 16'd65208;
    localparam logic [15:0] DECAY_SNARE = 16'd65012;
    localparam logic [15:0] DECAY_HAT   = 16'd64553;
    localparam logic [15:0] DECAY_STAB  = 16'd65405;

    localparam logic [15:0] AMP_SCALE = 16'd28000;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam int MUL_AW = 34;
    localparam int MUL_BW = 16;
    localparam int MUL_PW = MUL_AW + MUL_BW + 1;

    function automatic logic [15:0] lfsr_next(input logic [15:0] x);
        logic [15:0] y;
        y = {1'b0, x[15:1]};
        if (x[0]) begin
            y = y ^ LFSR_MASK;
        end
        return y;
    endfunction

    // raw register minus half scale, as Q15
    function automatic logic signed [15:0] noise_q15(input logic [15:0] x);
        return $signed({~x[15], x[14:0]});
    endfunction

endpackage
`default_nettype wire

>>> design/dss_mul.sv
`default_nettype none
module dss_mul import dss_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic signed [MUL_AW-1:0] mul_a,
    input  wire logic        [MUL_BW-1:0] mul_b,
    output logic signed      [MUL_PW-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * $signed({1'b0, mul_b});
    end

endmodule
`default_nettype wire

>>> design/dss_sine.sv
`default_nettype none
module dss_sine import dss_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [PHASE_BITS-1:0] phase,
    output sin_stat_t                  stat
);

    localparam int IDXW = $clog2(SINE_TABLE_DEPTH);
    localparam int HW   = IDXW - 1;
    localparam int H    = SINE_TABLE_DEPTH / 2;
    localparam int W    = 2 * HW + 20;
    localparam logic [W-1:0]  FIVE_HH = W'(5 * H * H);
    localparam logic [HW:0]   H_VAL   = (HW + 1)'(H);
    localparam logic [3:0]    TOP_BIT = 4'd14;

    sin_state_t     state_reg, state_next;
    logic [HW-1:0]  j_reg;
    logic           neg_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dsh_reg;
    logic [3:0]     cnt_reg;
    logic [14:0]    q_reg;

    logic [IDXW-1:0] idx;
    logic [HW:0]     hm;
    logic [2*HW:0]   p;
    logic [W-1:0]    num;
    logic [W-1:0]    den;
    logic            fits;

    assign idx  = phase[PHASE_BITS-1 -: IDXW];
    assign hm   = H_VAL - {1'b0, j_reg};
    assign p    = {{(HW + 1){1'b0}}, j_reg} * {{HW{1'b0}}, hm};
    assign num  = {p, 19'd0} - W'({p, 4'd0});
    assign den  = FIVE_HH - W'({p, 2'd0});
    assign fits = rem_reg >= dsh_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SN_IDLE: if (start) state_next = SN_LOAD;
            SN_LOAD: state_next = SN_DIV;
            SN_DIV:  if (cnt_reg == 4'd0) state_next = SN_DONE;
            SN_DONE: state_next = SN_IDLE;
            default: state_next = SN_IDLE;
        endcase
    end

    always_comb begin
        stat.done  = (state_reg == SN_DONE);
        stat.value = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SN_IDLE: begin
                if (start) begin
                    j_reg   <= idx[HW-1:0];
                    neg_reg <= idx[IDXW-1];
                end
            end
            SN_LOAD: begin
                rem_reg <= num;
                dsh_reg <= den << 14;
                cnt_reg <= TOP_BIT;
                q_reg   <= '0;
            end
            SN_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (fits) begin
                    rem_reg        <= rem_reg - dsh_reg;
                    q_reg[cnt_reg] <= 1'b1;
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 4'd1;
            end
            SN_DONE: ;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> design/drum_step_sequencer_synth.sv
`default_nettype none
// An accepted tick computes its sample into the output register: three sine evaluations
// (15-step divider), mixing on the shared multiplier and then scaling and saturation.
// Input stays closed until the sample enters the output register, which waits while a
// held result blocks it; an idle request is accepted without starting a computation.
// Reset (aresetn, synchronous, active low) restores the register defaults, step 0,
// phases and envelopes to zero, the noise seed.
module drum_step_sequencer_synth import dss_pkg::*; #(
    parameter int PATTERN_STEPS    = 16,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] sample_tick, [7:1] zero
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] sample_out, [19:16] step_index, [23:20] zero
    output logic             m_tuser,   // [0] step_started
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int STEPW = $clog2(PATTERN_STEPS);
    localparam logic [STEPW-1:0] LAST_STEP = STEPW'(PATTERN_STEPS - 1);
    localparam logic [63:0] KICK_INC64 = ((64'd160 << PHASE_BITS) + 64'd22050) / 64'd44100;
    localparam logic [63:0] SUB_INC64  = ((64'd40 << PHASE_BITS) + 64'd22050) / 64'd44100;
    localparam logic [63:0] STAB_INC64 = ((64'd400 << PHASE_BITS) + 64'd22050) / 64'd44100;
    localparam logic [PHASE_BITS-1:0] KICK_INC = KICK_INC64[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] SUB_INC  = SUB_INC64[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] STAB_INC = STAB_INC64[PHASE_BITS-1:0];
    localparam logic signed [63:0] TRUNC_BIAS = 64'sh1FFF_FFFF_FFFF;

    // configuration registers
    logic [15:0] sps_reg, kick_pat_reg, snare_pat_reg, hat_pat_reg, stab_pat_reg;

    // sequencer state
    dss_state_t       state_reg, state_next;
    logic [15:0]      tick_reg;
    logic [STEPW-1:0] step_reg;
    logic             first_reg;
    logic             started_reg;

    // voice state
    logic [PHASE_BITS-1:0] kick_ph_reg, sub_ph_reg, stab_ph_reg;
    logic [15:0]           env_reg [4];
    logic [15:0]           lfsr_reg;
    logic [15:0]           noise1_reg, noise2_reg;
    logic signed [15:0]    sin_reg [3];

    // datapath working registers
    logic [1:0]          sidx_reg;
    logic [2:0]          term_reg;
    logic signed [48:0]  acc_reg;
    logic [38:0]         lo_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic [3:0]  out_step_reg;
    logic        out_started_reg;

    logic                         s_acc, tick;
    logic                         seq_started;
    logic [15:0]                  tick_next;
    logic [STEPW-1:0]             step_next;
    logic [16:0]                  tick_plus;
    logic [STEPW+3:0]             step_ext;
    logic [STEPW+3:0]             step_cur;
    logic [3:0]                   pat_bit;
    logic                         sin_start;
    logic [PHASE_BITS-1:0]        sin_phase;
    sin_stat_t                    sin_stat;
    logic signed [MUL_AW-1:0]     mul_a;
    logic [MUL_BW-1:0]            mul_b;
    logic signed [MUL_PW-1:0]     prod_reg;
    logic signed [15:0]           term_x;
    logic [15:0]                  term_env;
    logic [15:0]                  term_gain;
    logic [15:0]                  term_decay;
    logic [1:0]                   env_sel;
    logic signed [63:0]           fin, fin_adj, fin_q;
    logic [15:0]                  sat;
    logic                         out_go;
    logic [15:0]                  n1, n2;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign tick      = s_acc && s_tdata[0];
    assign cfg_ready = 1'b1;
    assign out_go    = (state_reg == ST_FIN_C) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_step_reg, out_sample_reg};
    assign m_tuser  = out_started_reg;

    // step reported with a sample is the one held since its tick
    assign step_cur = {4'd0, step_reg};

    // step counting: a zero step length behaves as one
    always_comb begin
        tick_plus   = {1'b0, tick_reg} + 17'd1;
        tick_next   = tick_reg;
        step_next   = step_reg;
        seq_started = 1'b0;
        if (first_reg) begin
            seq_started = 1'b1;
        end else if (tick_plus >= {1'b0, sps_reg}) begin
            tick_next   = '0;
            step_next   = (step_reg == LAST_STEP) ? '0 : step_reg + STEPW'(1);
            seq_started = 1'b1;
        end else begin
            tick_next = tick_plus[15:0];
        end
        step_ext = {4'd0, step_next};
        pat_bit  = step_ext[3:0];
    end

    assign n1 = lfsr_next(lfsr_reg);
    assign n2 = lfsr_next(n1);

    dss_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_sine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sin_start),
        .phase   (sin_phase),
        .stat    (sin_stat)
    );

    dss_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // per-term operand selection
    always_comb begin
        term_x     = sin_reg[SIN_KICK];
        term_env   = env_reg[0];
        term_gain  = GAIN_KICK;
        term_decay = DECAY_KICK;
        env_sel    = 2'd0;
        unique case (term_reg)
            TERM_KICK: ;
            TERM_SNARE: begin
                term_x     = noise_q15(noise1_reg);
                term_env   = env_reg[1];
                term_gain  = GAIN_SNARE;
                term_decay = DECAY_SNARE;
                env_sel    = 2'd1;
            end
            TERM_HAT: begin
                term_x     = noise_q15(noise2_reg);
                term_env   = env_reg[2];
                term_gain  = GAIN_HAT;
                term_decay = DECAY_HAT;
                env_sel    = 2'd2;
            end
            TERM_SUB: begin
                term_x    = sin_reg[SIN_SUB];
                term_env  = ENV_ONE;
                term_gain = GAIN_SUB;
            end
            TERM_STAB: begin
                term_x     = sin_reg[SIN_STAB];
                term_env   = env_reg[3];
                term_gain  = GAIN_STAB;
                term_decay = DECAY_STAB;
                env_sel    = 2'd3;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (sidx_reg)
            SIN_KICK: sin_phase = kick_ph_reg;
            SIN_SUB:  sin_phase = sub_ph_reg;
            SIN_STAB: sin_phase = stab_ph_reg;
            default:  sin_phase = kick_ph_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (tick) state_next = ST_SIN_GO;
            ST_SIN_GO:   state_next = ST_SIN_WAIT;
            ST_SIN_WAIT: begin
                if (sin_stat.done) begin
                    state_next = (sidx_reg == SIN_STAB) ? ST_TERM_A : ST_SIN_GO;
                end
            end
            ST_TERM_A:   state_next = ST_TERM_B;
            ST_TERM_B:   state_next = ST_TERM_C;
            ST_TERM_C:   state_next = ST_TERM_D;
            ST_TERM_D:   state_next = (term_reg == TERM_STAB) ? ST_FIN_A : ST_TERM_A;
            ST_FIN_A:    state_next = ST_FIN_B;
            ST_FIN_B:    state_next = ST_FIN_C;
            ST_FIN_C:    if (out_go) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and sine start
    always_comb begin
        sin_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_SIN_GO: sin_start = 1'b1;
            ST_TERM_A: begin
                // sample times envelope
                mul_a = MUL_AW'(term_x);
                mul_b = term_env;
            end
            ST_TERM_B: begin
                // then times the voice gain
                mul_a = prod_reg[MUL_AW-1:0];
                mul_b = term_gain;
            end
            ST_TERM_C: begin
                // envelope decay
                mul_a = {18'd0, term_env};
                mul_b = term_decay;
            end
            ST_FIN_A: begin
                mul_a = {10'd0, acc_reg[23:0]};
                mul_b = AMP_SCALE;
            end
            ST_FIN_B, ST_FIN_C: begin
                // keep the upper product steady while the result waits
                mul_a = {{9{acc_reg[48]}}, acc_reg[48:24]};
                mul_b = AMP_SCALE;
            end
            default: ;
        endcase
    end

    // scale by 2^-45 truncating toward zero, then saturate
    always_comb begin
        fin     = $signed({prod_reg[39:0], 24'd0}) + $signed({25'd0, lo_reg});
        fin_adj = fin[63] ? fin + TRUNC_BIAS : fin;
        fin_q   = fin_adj >>> 45;
        if (fin_q > 64'sd32767) begin
            sat = 16'h7FFF;
        end else if (fin_q < -64'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = fin_q[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sps_reg       <= RST_SAMPLES_PER_STEP;
            kick_pat_reg  <= RST_KICK_PATTERN;
            snare_pat_reg <= RST_SNARE_PATTERN;
            hat_pat_reg   <= RST_HAT_PATTERN;
            stab_pat_reg  <= RST_STAB_PATTERN;
            tick_reg      <= '0;
            step_reg      <= '0;
            first_reg     <= 1'b1;
            kick_ph_reg   <= '0;
            sub_ph_reg    <= '0;
            stab_ph_reg   <= '0;
            env_reg[0]    <= '0;
            env_reg[1]    <= '0;
            env_reg[2]    <= '0;
            env_reg[3]    <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration: unknown indexes drop silently
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SAMPLES_PER_STEP: sps_reg       <= cfg_data;
                    REG_KICK_PATTERN:     kick_pat_reg  <= cfg_data;
                    REG_SNARE_PATTERN:    snare_pat_reg <= cfg_data;
                    REG_HAT_PATTERN:      hat_pat_reg   <= cfg_data;
                    REG_STAB_PATTERN:     stab_pat_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (tick) begin
                // advance the sequencer and retrigger the voices of the new step
                first_reg  <= 1'b0;
                tick_reg   <= tick_next;
                step_reg   <= step_next;
                lfsr_reg   <= n2;
                sub_ph_reg <= sub_ph_reg + SUB_INC;
                if (seq_started && kick_pat_reg[pat_bit])  env_reg[0] <= ENV_ONE;
                if (seq_started && snare_pat_reg[pat_bit]) env_reg[1] <= ENV_ONE;
                if (seq_started && hat_pat_reg[pat_bit])   env_reg[2] <= ENV_ONE;
                if (seq_started && stab_pat_reg[pat_bit])  env_reg[3] <= ENV_HALF;
            end

            if (state_reg == ST_TERM_D && term_reg != TERM_SUB) begin
                env_reg[env_sel] <= prod_reg[31:16];
            end

            if (out_go) begin
                kick_ph_reg <= kick_ph_reg + KICK_INC;
                stab_ph_reg <= stab_ph_reg + STAB_INC;
            end

            // hold the result until taken
            if (out_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (tick) begin
            started_reg <= seq_started;
            noise1_reg  <= n1;
            noise2_reg  <= n2;
            sidx_reg    <= SIN_KICK;
            term_reg    <= TERM_KICK;
            acc_reg     <= '0;
        end
        if (state_reg == ST_SIN_WAIT && sin_stat.done) begin
            sin_reg[sidx_reg] <= sin_stat.value;
            sidx_reg          <= sidx_reg + 2'd1;
        end
        if (state_reg == ST_TERM_C) begin
            acc_reg <= acc_reg + prod_reg[48:0];
        end
        if (state_reg == ST_TERM_D) begin
            term_reg <= term_reg + 3'd1;
        end
        if (state_reg == ST_FIN_B) begin
            lo_reg <= prod_reg[38:0];
        end
        if (out_go) begin
            out_sample_reg  <= sat;
            out_step_reg    <= step_cur[3:0];
            out_started_reg <= started_reg;
        end
    end

`ifndef SYNTH
    // envelopes never rise above full scale
    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg[0] <= ENV_ONE && env_reg[1] <= ENV_ONE &&
        env_reg[2] <= ENV_ONE && env_reg[3] <= ENV_ONE)
        else $error("envelope above full scale");

    // the noise register never locks up at zero
    a_lfsr_live: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != 16'd0)
        else $error("noise register reached zero");

    // the sine unit reports only while the sequencer waits on it
    a_sin_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        sin_stat.done |-> state_reg == ST_SIN_WAIT)
        else $error("sine result with no waiting sequencer");

    // a tick starts a computation and input stays closed meanwhile
    a_busy_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        tick |=> !s_tready && state_reg == ST_SIN_GO)
        else $error("input reopened during a computation");
`endif

endmodule
`default_nettype wire
